@@ src/temp_pressure_humidity_compensation_top_defines.svh @@
// assertion macros shared by the compensation block
// no dependencies; the asserting modules expect signals named clk and rst_n
`ifndef TEMP_PRESSURE_HUMIDITY_COMPENSATION_TOP_DEFINES_SVH
`define TEMP_PRESSURE_HUMIDITY_COMPENSATION_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TPHC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TPHC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tphc_pkg.sv @@
// types, constants and helper functions of the compensation block
// no dependencies
package tphc_pkg;

    localparam int unsigned DIV_W = 32;

    localparam logic [2:0] CFG_TEMP_COEFFS       = 3'd0;
    localparam logic [2:0] CFG_PRESS_COEFFS_LOW  = 3'd1;
    localparam logic [2:0] CFG_PRESS_COEFFS_HIGH = 3'd2;
    localparam logic [2:0] CFG_PRESS_COEFF_NINE  = 3'd3;
    localparam logic [2:0] CFG_HUM_COEFFS        = 3'd4;

    localparam logic [31:0] P_OFFSET   = 32'd64000;
    localparam logic [31:0] P_FULL     = 32'd1048576;
    localparam logic [31:0] P_SCALE    = 32'd3125;
    localparam logic [31:0] P_ONE      = 32'd32768;
    localparam logic [31:0] H_OFFSET   = 32'd76800;
    localparam logic [31:0] H_ROUND    = 32'd16384;
    localparam logic [31:0] H_BIAS     = 32'd2097152;
    localparam logic [31:0] H_ROUND2   = 32'd8192;
    localparam logic [31:0] H_MAX      = 32'd419430400;
    localparam logic [31:0] T_ROUND    = 32'd128;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } request_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_pa;
        logic [16:0]        humidity_q10;
        logic               divide_by_zero;
    } result_t;

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] temp;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } mid_t;

    typedef struct packed {
        logic [47:0] temp_coeffs;
        logic [63:0] press_coeffs_low;
        logic [63:0] press_coeffs_high;
        logic [15:0] press_coeff_nine;
        logic [63:0] hum_coeffs;
    } calib_t;

    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        mode;
        logic        dz;
    } div_side_t;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        logic signed [31:0] s;
        s = $signed(x) >>> n;
        return $unsigned(s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

@@ src/tphc_fifo.sv @@
// small register queue used between front and back and at the result side
// depends on temp_pressure_humidity_compensation_top_defines.svh for assertions
`include "temp_pressure_humidity_compensation_top_defines.svh"

module tphc_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TPHC_ASSERT_IMP(a_fifo_bound, 1'b1, count_reg <= CW'(DEPTH), "fifo count over depth")
    `TPHC_ASSERT_IMP(a_fifo_flags, 1'b1, !(full && empty), "fifo full and empty")
    `TPHC_ASSERT_NXT(a_fifo_grow, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "fifo count did not grow")

endmodule

@@ src/tphc_front.sv @@
// front part: takes requests and computes fine temperature and temperature
// depends on tphc_pkg
module tphc_front import tphc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  calib_t   calib,
    input  logic     in_push,
    input  request_t in_data,
    output logic     in_full,
    output logic     mid_push,
    output mid_t     mid_data,
    input  logic     mid_full
);

    logic        adv;
    logic [31:0] t1, t2, t3, adc_t, a0, d0;

    logic        f1_valid_reg, f2_valid_reg, f3_valid_reg, f4_valid_reg;
    request_t    f1_req_reg, f2_req_reg, f3_req_reg, f4_req_reg;
    logic [31:0] f1_pa_reg, f1_pa_next, f1_dd_reg, f1_dd_next;
    logic [31:0] f2_a_reg, f2_a_next, f2_bm_reg, f2_bm_next;
    logic [31:0] f3_fine_reg, f3_fine_next;
    logic [31:0] f4_fine_reg, f4_temp_reg, f4_temp_next;

    assign adv     = !(f4_valid_reg && mid_full);
    assign in_full = !adv;

    assign t1    = {16'b0, calib.temp_coeffs[15:0]};
    assign t2    = sx16(calib.temp_coeffs[31:16]);
    assign t3    = sx16(calib.temp_coeffs[47:32]);
    assign adc_t = {12'b0, in_data.raw_temperature};

    always_comb
    begin
        a0           = (adc_t >> 3) - (t1 << 1);
        d0           = (adc_t >> 4) - t1;
        f1_pa_next   = a0 * t2;
        f1_dd_next   = d0 * d0;
        f2_a_next    = asr(f1_pa_reg, 11);
        f2_bm_next   = asr(f1_dd_reg, 12) * t3;
        f3_fine_next = f2_a_reg + asr(f2_bm_reg, 14);
        // times five by shift and add, then round
        f4_temp_next = asr((f3_fine_reg << 2) + f3_fine_reg + T_ROUND, 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= in_push;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_req_reg  <= in_data;
            f1_pa_reg   <= f1_pa_next;
            f1_dd_reg   <= f1_dd_next;
            f2_req_reg  <= f1_req_reg;
            f2_a_reg    <= f2_a_next;
            f2_bm_reg   <= f2_bm_next;
            f3_req_reg  <= f2_req_reg;
            f3_fine_reg <= f3_fine_next;
            f4_req_reg  <= f3_req_reg;
            f4_fine_reg <= f3_fine_reg;
            f4_temp_reg <= f4_temp_next;
        end
    end

    assign mid_push              = f4_valid_reg && adv;
    assign mid_data.fine         = f4_fine_reg;
    assign mid_data.temp         = f4_temp_reg;
    assign mid_data.raw_pressure = f4_req_reg.raw_pressure;
    assign mid_data.raw_humidity = f4_req_reg.raw_humidity;

endmodule

@@ src/tphc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, unsigned 32 bit
// depends on tphc_pkg
module tphc_div import tphc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    input  div_side_t        side_in,
    output logic             out_valid,
    output logic [DIV_W-1:0] quot,
    output div_side_t        side_out
);

    logic             vld_reg  [DIV_W];
    logic [DIV_W-1:0] rem_reg  [DIV_W];
    logic [DIV_W-1:0] nq_reg   [DIV_W];
    logic [DIV_W-1:0] den_reg  [DIV_W];
    div_side_t        side_reg [DIV_W];

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_stage
        logic             vld_in;
        logic [DIV_W-1:0] rem_in, nq_in, den_in;
        div_side_t        side_s;
        logic [DIV_W:0]   trial;
        logic             ge;
        logic [DIV_W-1:0] rem_next, nq_next;

        if (i == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
            assign side_s = side_in;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign den_in = den_reg[i-1];
            assign side_s = side_reg[i-1];
        end

        always_comb
        begin
            trial    = {rem_in, nq_in[DIV_W-1]};
            ge       = (trial >= {1'b0, den_in});
            rem_next = ge ? DIV_W'(trial - {1'b0, den_in}) : trial[DIV_W-1:0];
            nq_next  = {nq_in[DIV_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                nq_reg[i]   <= nq_next;
                den_reg[i]  <= den_in;
                side_reg[i] <= side_s;
            end
        end
    end

    assign out_valid = vld_reg[DIV_W-1];
    assign quot      = nq_reg[DIV_W-1];
    assign side_out  = side_reg[DIV_W-1];

endmodule

@@ src/tphc_back.sv @@
// back part: pressure and humidity pipelines around the shared-rate divider
// depends on tphc_pkg, tphc_div and the assertion header
`include "temp_pressure_humidity_compensation_top_defines.svh"

module tphc_back import tphc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  calib_t  calib,
    input  logic    mid_empty,
    input  mid_t    mid_data,
    output logic    mid_pop,
    output logic    out_push,
    output result_t out_data,
    input  logic    out_full
);

    logic        adv;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] b_a, b_qa, b_hd, b_hx;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic        q1_valid_reg, q2_valid_reg;

    logic [31:0] s1_q_reg, s1_q_next, s1_m5_reg, s1_m5_next, s1_m2_reg, s1_m2_next;
    logic [31:0] s1_hm5_reg, s1_hm5_next, s1_hm6_reg, s1_hm6_next;
    logic [31:0] s1_hm3_reg, s1_hm3_next, s1_hx_reg, s1_temp_reg;
    logic [19:0] s1_adcp_reg;

    logic [31:0] s2_b6_reg, s2_b6_next, s2_m3_reg, s2_m3_next, s2_m5_reg, s2_m2_reg;
    logic [31:0] s2_ha_reg, s2_ha_next, s2_ht_reg, s2_ht_next, s2_temp_reg;
    logic [19:0] s2_adcp_reg;

    logic [31:0] s3_b_reg, s3_b_next, s3_a2_reg, s3_a2_next, s3_hbb_reg, s3_hbb_next;
    logic [31:0] s3_ha_reg, s3_temp_reg;
    logic [19:0] s3_adcp_reg;

    logic [31:0] s4_a3m_reg, s4_a3m_next, s4_p0_reg, s4_p0_next;
    logic [31:0] s4_hdd_reg, s4_hdd_next, s4_temp_reg;

    logic [31:0] s5_div_reg, s5_div_next, s5_p1_reg, s5_p1_next;
    logic [31:0] s5_hdd_reg, s5_hss_reg, s5_hss_next, s5_temp_reg;

    logic [31:0] s6_hm_reg, s6_hm_next, s6_hdd_reg, s6_num_reg, s6_num_next;
    logic [31:0] s6_den_reg, s6_temp_reg;
    logic        s6_mode_reg, s6_dz_reg;

    logic [31:0] h_fin, h_clamp;
    div_side_t   div_side_in, div_side_out;
    logic        div_valid;
    logic [31:0] div_quot;

    logic [31:0] q1_pres_reg, q1_pres_next, q1_sq_reg, q1_sq_next, q1_m8_reg, q1_m8_next;
    div_side_t   q1_side_reg;
    logic [31:0] q2_pres_reg, q2_m9_reg, q2_m9_next, q2_m8_reg;
    div_side_t   q2_side_reg;
    logic [31:0] p_fin;

    assign adv     = !(q2_valid_reg && out_full);
    assign mid_pop = adv && !mid_empty;

    assign p1 = {16'b0, calib.press_coeffs_low[15:0]};
    assign p2 = sx16(calib.press_coeffs_low[31:16]);
    assign p3 = sx16(calib.press_coeffs_low[47:32]);
    assign p4 = sx16(calib.press_coeffs_low[63:48]);
    assign p5 = sx16(calib.press_coeffs_high[15:0]);
    assign p6 = sx16(calib.press_coeffs_high[31:16]);
    assign p7 = sx16(calib.press_coeffs_high[47:32]);
    assign p8 = sx16(calib.press_coeffs_high[63:48]);
    assign p9 = sx16(calib.press_coeff_nine);
    assign h1 = {24'b0, calib.hum_coeffs[7:0]};
    assign h2 = sx16(calib.hum_coeffs[23:8]);
    assign h3 = {24'b0, calib.hum_coeffs[31:24]};
    assign h4 = sx12(calib.hum_coeffs[43:32]);
    assign h5 = sx12(calib.hum_coeffs[55:44]);
    assign h6 = sx8(calib.hum_coeffs[63:56]);

    always_comb
    begin
        // stage 1: offsets and first products
        b_a         = asr(mid_data.fine, 1) - P_OFFSET;
        b_qa        = asr(b_a, 2);
        b_hd        = mid_data.fine - H_OFFSET;
        b_hx        = ({16'b0, mid_data.raw_humidity} << 14) - (h4 << 20) + H_ROUND;
        s1_q_next   = b_qa * b_qa;
        s1_m5_next  = b_a * p5;
        s1_m2_next  = p2 * b_a;
        s1_hm5_next = h5 * b_hd;
        s1_hm6_next = b_hd * h6;
        s1_hm3_next = b_hd * h3;
        // stage 2
        s2_b6_next  = asr(s1_q_reg, 11) * p6;
        s2_m3_next  = p3 * asr(s1_q_reg, 13);
        s2_ha_next  = asr(s1_hx_reg - s1_hm5_reg, 15);
        s2_ht_next  = asr(s1_hm6_reg, 10) * (asr(s1_hm3_reg, 11) + P_ONE);
        // stage 3
        s3_b_next   = asr(s2_b6_reg + (s2_m5_reg << 1), 2) + (p4 << 16);
        s3_a2_next  = asr(asr(s2_m3_reg, 3) + asr(s2_m2_reg, 1), 18);
        s3_hbb_next = (asr(s2_ht_reg, 10) + H_BIAS) * h2 + H_ROUND2;
        // stage 4
        s4_a3m_next = (P_ONE + s3_a2_reg) * p1;
        s4_p0_next  = (P_FULL - {12'b0, s3_adcp_reg}) - asr(s3_b_reg, 12);
        s4_hdd_next = s3_ha_reg * asr(s3_hbb_reg, 14);
        // stage 5
        s5_div_next = asr(s4_a3m_reg, 15);
        s5_p1_next  = s4_p0_reg * P_SCALE;
        s5_hss_next = asr(s4_hdd_reg, 15) * asr(s4_hdd_reg, 15);
        // stage 6: dividend set up so the quotient fits in 32 bits
        s6_hm_next  = asr(s5_hss_reg, 7) * h1;
        s6_num_next = s5_p1_reg[31] ? s5_p1_reg : (s5_p1_reg << 1);
        // humidity finish and clamp
        h_fin = s6_hdd_reg - asr(s6_hm_reg, 4);
        if (h_fin[31])
        begin
            h_clamp = '0;
        end
        else if (h_fin > H_MAX)
        begin
            h_clamp = H_MAX;
        end
        else
        begin
            h_clamp = h_fin;
        end
        // after the divider
        q1_pres_next = div_side_out.mode ? (div_quot << 1) : div_quot;
        q1_sq_next   = (q1_pres_next >> 3) * (q1_pres_next >> 3);
        q1_m8_next   = (q1_pres_next >> 2) * p8;
        q2_m9_next   = p9 * (q1_sq_reg >> 13);
        p_fin        = q2_pres_reg + asr(asr(q2_m9_reg, 12) + asr(q2_m8_reg, 13) + p7, 4);
    end

    assign div_side_in.temp = s6_temp_reg;
    assign div_side_in.hum  = h_clamp[28:12];
    assign div_side_in.mode = s6_mode_reg;
    assign div_side_in.dz   = s6_dz_reg;

    tphc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s6_valid_reg),
        .num       (s6_num_reg),
        .den       (s6_den_reg),
        .side_in   (div_side_in),
        .out_valid (div_valid),
        .quot      (div_quot),
        .side_out  (div_side_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0;
            q2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= !mid_empty;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            q1_valid_reg <= div_valid;
            q2_valid_reg <= q1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_q_reg    <= s1_q_next;
            s1_m5_reg   <= s1_m5_next;
            s1_m2_reg   <= s1_m2_next;
            s1_hm5_reg  <= s1_hm5_next;
            s1_hm6_reg  <= s1_hm6_next;
            s1_hm3_reg  <= s1_hm3_next;
            s1_hx_reg   <= b_hx;
            s1_temp_reg <= mid_data.temp;
            s1_adcp_reg <= mid_data.raw_pressure;

            s2_b6_reg   <= s2_b6_next;
            s2_m3_reg   <= s2_m3_next;
            s2_m5_reg   <= s1_m5_reg;
            s2_m2_reg   <= s1_m2_reg;
            s2_ha_reg   <= s2_ha_next;
            s2_ht_reg   <= s2_ht_next;
            s2_temp_reg <= s1_temp_reg;
            s2_adcp_reg <= s1_adcp_reg;

            s3_b_reg    <= s3_b_next;
            s3_a2_reg   <= s3_a2_next;
            s3_hbb_reg  <= s3_hbb_next;
            s3_ha_reg   <= s2_ha_reg;
            s3_temp_reg <= s2_temp_reg;
            s3_adcp_reg <= s2_adcp_reg;

            s4_a3m_reg  <= s4_a3m_next;
            s4_p0_reg   <= s4_p0_next;
            s4_hdd_reg  <= s4_hdd_next;
            s4_temp_reg <= s3_temp_reg;

            s5_div_reg  <= s5_div_next;
            s5_p1_reg   <= s5_p1_next;
            s5_hdd_reg  <= s4_hdd_reg;
            s5_hss_reg  <= s5_hss_next;
            s5_temp_reg <= s4_temp_reg;

            s6_hm_reg   <= s6_hm_next;
            s6_hdd_reg  <= s5_hdd_reg;
            s6_num_reg  <= s6_num_next;
            s6_mode_reg <= s5_p1_reg[31];
            s6_den_reg  <= s5_div_reg;
            s6_dz_reg   <= (s5_div_reg == '0);
            s6_temp_reg <= s5_temp_reg;

            q1_pres_reg <= q1_pres_next;
            q1_sq_reg   <= q1_sq_next;
            q1_m8_reg   <= q1_m8_next;
            q1_side_reg <= div_side_out;

            q2_pres_reg <= q1_pres_reg;
            q2_m9_reg   <= q2_m9_next;
            q2_m8_reg   <= q1_m8_reg;
            q2_side_reg <= q1_side_reg;
        end
    end

    assign out_push                   = q2_valid_reg && adv;
    assign out_data.temperature_centi = $signed(q2_side_reg.temp);
    assign out_data.pressure_pa       = q2_side_reg.dz ? '0 : p_fin;
    assign out_data.humidity_q10      = q2_side_reg.hum;
    assign out_data.divide_by_zero    = q2_side_reg.dz;

    `TPHC_ASSERT_IMP(a_dz_zero, q2_valid_reg && q2_side_reg.dz, out_data.pressure_pa == '0, "pressure not zero on zero divisor")

endmodule

@@ src/temp_pressure_humidity_compensation_top.sv @@
// top level of the sensor compensation block: config registers and queues
// depends on tphc_pkg, tphc_front, tphc_fifo, tphc_back
//
// Compensates one set of raw temperature, pressure and humidity readings per request
// into temperature in 0.01 degC, pressure in Pa and humidity in 1/1024 %, using the
// 32-bit wrapping integer method with the factory calibration words written through
// the config port. Fine temperature is computed first and all three outputs use the
// fine temperature of the same request. A new request is taken every cycle while
// full is low. Most of the path from request to result lies in the 32-stage
// restoring divider (one quotient bit per stage) that turns the pressure term
// into pascals. A zero pressure divisor gives pressure_pa 0 with divide_by_zero
// set. Config registers may only be written while no request is in flight.
module temp_pressure_humidity_compensation_top import tphc_pkg::*; #(
    parameter int unsigned MID_DEPTH = 2,
    parameter int unsigned OUT_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        push,
    input  request_t    request,
    output logic        full,
    // result side
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    // config write port
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // calibration words, all zero after reset
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_coeffs_low_reg;
    logic [63:0] press_coeffs_high_reg;
    logic [15:0] press_coeff_nine_reg;
    logic [63:0] hum_coeffs_reg;
    calib_t      calib;

    // queue between front and back
    logic                 mid_push, mid_full, mid_pop, mid_empty;
    mid_t                 mid_wdata;
    logic [$bits(mid_t)-1:0] mid_rdata;

    // result queue
    logic                    out_push, out_full;
    result_t                 out_wdata;
    logic [$bits(result_t)-1:0] out_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg       <= '0;
            press_coeffs_low_reg  <= '0;
            press_coeffs_high_reg <= '0;
            press_coeff_nine_reg  <= '0;
            hum_coeffs_reg        <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TEMP_COEFFS:       temp_coeffs_reg       <= cfg_data[47:0];
                CFG_PRESS_COEFFS_LOW:  press_coeffs_low_reg  <= cfg_data;
                CFG_PRESS_COEFFS_HIGH: press_coeffs_high_reg <= cfg_data;
                CFG_PRESS_COEFF_NINE:  press_coeff_nine_reg  <= cfg_data[15:0];
                CFG_HUM_COEFFS:        hum_coeffs_reg        <= cfg_data;
                default:               ;  // unknown index, write dropped
            endcase
        end
    end

    assign calib.temp_coeffs       = temp_coeffs_reg;
    assign calib.press_coeffs_low  = press_coeffs_low_reg;
    assign calib.press_coeffs_high = press_coeffs_high_reg;
    assign calib.press_coeff_nine  = press_coeff_nine_reg;
    assign calib.hum_coeffs        = hum_coeffs_reg;

    // front: accepts requests, computes fine temperature and temperature
    tphc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .calib    (calib),
        .in_push  (push),
        .in_data  (request),
        .in_full  (full),
        .mid_push (mid_push),
        .mid_data (mid_wdata),
        .mid_full (mid_full)
    );

    // short queue so front and back stall on their own
    tphc_fifo #(
        .WIDTH ($bits(mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (mid_wdata),
        .full      (mid_full),
        .pop       (mid_pop),
        .pop_data  (mid_rdata),
        .empty     (mid_empty)
    );

    // back: pressure with divider, humidity with clamp
    tphc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .calib     (calib),
        .mid_empty (mid_empty),
        .mid_data  (mid_t'(mid_rdata)),
        .mid_pop   (mid_pop),
        .out_push  (out_push),
        .out_data  (out_wdata),
        .out_full  (out_full)
    );

    // result queue decouples the consumer from the back pipeline
    tphc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_wdata),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (out_rdata),
        .empty     (empty)
    );

    assign result = result_t'(out_rdata);

endmodule
